/* sv/kmsd_pkg.sv */
// kmsd_pkg: widths, reset constants and the 16-bit population count shared
// by the key matrix scan debouncer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kmsd_pkg;

  localparam int ROW_IDX_W = 4;
  localparam int COL_W     = 16;
  localparam int CNT_W     = 8;
  localparam int TOTAL_W   = 9;
  localparam int POP_W     = 5;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd5;

  typedef logic [COL_W-1:0]   col_word_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [POP_W-1:0]   pop_t;

  function automatic pop_t popcount16(input col_word_t v);
    pop_t n;
    n = '0;
    for (int i = 0; i < COL_W; i++) begin
      n = n + pop_t'(v[i]);
    end
    return n;
  endfunction

endpackage : kmsd_pkg

`default_nettype wire

/* sv/key_matrix_scan_debounce.sv */
// key_matrix_scan_debounce: key matrix debouncer with one shared countdown.
// Depends on kmsd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one row sample per word:
//   row_index, column_bits (active high), end_of_scan on the last row of a
//   scan. Output channel (out_valid/out_ready) returns one word per input:
//   committed_row of that row, stable, and pressed_total of the whole
//   committed matrix.
//   Config channel (cfg_valid/cfg_ready/cfg_data) sets debounce_scans; it is
//   always ready and only changes the reload value.
//   State updates and the result register loads at the accepting edge. The
//   block takes one word per cycle unless the receiver stalls; the single result
//   register accepts a new word in the same cycle its old word is taken.
//   pressed_total comes from running counters (raw and committed), so no
//   full-matrix count is needed per word.
//   Reset clears both matrices and the counters, loads debounce_scans and
//   the countdown with 5 and empties the result register.
//   When the receiver stalls, the result holds and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_scan_debounce #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [kmsd_pkg::CNT_W-1:0]            cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [kmsd_pkg::ROW_IDX_W-1:0]        row_index,
  input  wire  [kmsd_pkg::COL_W-1:0]            column_bits,
  input  wire                                   end_of_scan,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [kmsd_pkg::COL_W-1:0]            committed_row,
  output logic                                  stable,
  output logic [kmsd_pkg::TOTAL_W-1:0]          pressed_total
);
  import kmsd_pkg::*;

  localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [COLS-1:0] raw_rows [ROWS];
  logic [COLS-1:0] committed_rows [ROWS];
  cnt_t            countdown;
  cnt_t            debounce_scans;
  total_t          raw_total;
  total_t          committed_total;

  logic            accept;
  logic            row_ok;
  logic [RIW-1:0]  ridx;
  logic [COLS-1:0] sample;
  logic [COLS-1:0] raw_cur;
  logic            changed;
  cnt_t            reload;
  cnt_t            cnt_mid;
  cnt_t            countdown_next;
  logic            commit;
  total_t          raw_total_next;
  col_word_t       row_result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    row_ok  = 32'(row_index) < ROWS;
    ridx    = row_index[RIW-1:0];
    sample  = column_bits[COLS-1:0];
    raw_cur = row_ok ? raw_rows[ridx] : '0;
    changed = row_ok && (raw_cur != sample);
    reload  = (debounce_scans != '0) ? debounce_scans : cnt_t'(1);
    cnt_mid = changed ? reload : countdown;
    countdown_next = cnt_mid;
    commit  = 1'b0;
    if (end_of_scan && cnt_mid != '0) begin
      countdown_next = cnt_mid - cnt_t'(1);
      commit         = (countdown_next == '0);
    end
    raw_total_next = raw_total;
    if (changed) begin
      raw_total_next = raw_total - total_t'(popcount16(col_word_t'(raw_cur)))
                                 + total_t'(popcount16(col_word_t'(sample)));
    end
    if (!row_ok) begin
      row_result = '0;
    end else if (commit) begin
      row_result = col_word_t'(sample);
    end else begin
      row_result = col_word_t'(committed_rows[ridx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_scans <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      debounce_scans <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        raw_rows[r]       <= '0;
        committed_rows[r] <= '0;
      end
      countdown       <= DEBOUNCE_RESET;
      raw_total       <= '0;
      committed_total <= '0;
    end else if (accept) begin
      for (int r = 0; r < ROWS; r++) begin
        if (commit) begin
          committed_rows[r] <= (changed && ridx == RIW'(r)) ? sample : raw_rows[r];
        end
        if (changed && ridx == RIW'(r)) begin
          raw_rows[r] <= sample;
        end
      end
      countdown <= countdown_next;
      raw_total <= raw_total_next;
      if (commit) begin
        committed_total <= raw_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      committed_row <= row_result;
      stable        <= (countdown_next == '0);
      pressed_total <= commit ? raw_total_next : committed_total;
    end
  end

  // settled countdown means committed matrix mirrors raw matrix
  a_settled_totals : assert property (@(posedge clk) disable iff (rst)
    (countdown == '0) |-> (committed_total == raw_total))
    else $error("committed and raw totals differ while settled");

  a_reload_nonzero : assert property (@(posedge clk) disable iff (rst)
    (accept && changed && !end_of_scan) |=> (countdown != '0))
    else $error("countdown zero after reload");

  a_accept_result : assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

endmodule : key_matrix_scan_debounce

`default_nettype wire
